// ----- src/nla_pkg.sv -----
// Shared constants, codes and controller/datapath interface types.
package nla_pkg;

  // Default table depth
  localparam int unsigned MaxLandmarksDefault = 64;

  // Field widths
  localparam int unsigned IdW  = 16;
  localparam int unsigned PosW = 32;

  // Command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load_in;     // capture observation position
    logic    clear;       // empty the table
    logic    append;      // store landmark from the input beat
    logic    scan_first;  // reset scan address and best-match tracking
    logic    scan_issue;  // read one table entry and advance
    logic    finish;      // load result registers and strobe done
    logic    fin_match;   // result carries the best match
    status_e fin_status;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic last_issue;  // scan address points at the last stored entry
    logic pipe_idle;   // no entry in flight through the distance pipeline
  } dp_stat_t;

endpackage

// ----- src/nla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module nla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/nla_datapath.sv -----
// Landmark table, squared-distance pipeline, best-match tracking and result registers.
module nla_datapath #(
  parameter int unsigned MaxLandmarks = nla_pkg::MaxLandmarksDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nla_pkg::dp_cmd_t              cmd_i,
  output nla_pkg::dp_stat_t             stat_o,
  input  logic [nla_pkg::IdW-1:0]       landmark_id_i,
  input  logic signed [nla_pkg::PosW-1:0] pos_x_i,
  input  logic signed [nla_pkg::PosW-1:0] pos_y_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [nla_pkg::IdW-1:0]       matched_id_o,
  output logic signed [nla_pkg::PosW-1:0] residual_x_o,
  output logic signed [nla_pkg::PosW-1:0] residual_y_o
);
  import nla_pkg::*;

  localparam int unsigned AW = (MaxLandmarks > 1) ? $clog2(MaxLandmarks) : 1;
  localparam int unsigned CW = $clog2(MaxLandmarks + 1);
  localparam int unsigned EW = IdW + 2 * PosW;

  // Table fill count and scan address
  logic [CW-1:0] count_q;
  logic [AW-1:0] addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.append && !stat_o.count_full) begin
      count_q <= count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_first) begin
      addr_q <= '0;
    end else if (cmd_i.scan_issue) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  // Observation position for the running query
  logic [PosW-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
  end

  // Landmark table: {id, x, y}
  logic [EW-1:0] rd_entry;

  nla_ram #(
    .Width(EW),
    .Depth(MaxLandmarks),
    .AddrW(AW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.append && !stat_o.count_full),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({landmark_id_i, pos_x_i, pos_y_i}),
    .raddr_i(addr_q),
    .rdata_o(rd_entry)
  );

  // Pipeline valid bits: read data, magnitudes, squares
  logic v1_q, v2_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 2: absolute coordinate differences
  logic [IdW-1:0]  e1_id;
  logic [PosW-1:0] e1_x, e1_y;
  logic [PosW:0]   dx, dy, ndx, ndy;
  logic [PosW-1:0] mag_x, mag_y;

  assign {e1_id, e1_x, e1_y} = rd_entry;

  always_comb begin
    dx    = {px_q[PosW-1], px_q} - {e1_x[PosW-1], e1_x};
    dy    = {py_q[PosW-1], py_q} - {e1_y[PosW-1], e1_y};
    ndx   = ~dx + (PosW+1)'(1);
    ndy   = ~dy + (PosW+1)'(1);
    mag_x = dx[PosW] ? ndx[PosW-1:0] : dx[PosW-1:0];
    mag_y = dy[PosW] ? ndy[PosW-1:0] : dy[PosW-1:0];
  end

  logic [PosW-1:0] mag_x_q, mag_y_q;
  logic [IdW-1:0]  e2_id_q;
  logic [PosW-1:0] e2_x_q, e2_y_q;

  always_ff @(posedge clk_i) begin
    mag_x_q <= mag_x;
    mag_y_q <= mag_y;
    e2_id_q <= e1_id;
    e2_x_q  <= e1_x;
    e2_y_q  <= e1_y;
  end

  // Stage 3: squares
  logic [2*PosW-1:0] sq_x_q, sq_y_q;
  logic [IdW-1:0]    e3_id_q;
  logic [PosW-1:0]   e3_x_q, e3_y_q;

  always_ff @(posedge clk_i) begin
    sq_x_q  <= mag_x_q * mag_x_q;
    sq_y_q  <= mag_y_q * mag_y_q;
    e3_id_q <= e2_id_q;
    e3_x_q  <= e2_x_q;
    e3_y_q  <= e2_y_q;
  end

  // Stage 4: sum and strict compare; earliest of equal distances stays
  logic [2*PosW:0] dist_sum;
  logic            have_q;
  logic [2*PosW:0] best_dist_q;
  logic [IdW-1:0]  best_id_q;
  logic [PosW-1:0] best_x_q, best_y_q;

  assign dist_sum = {1'b0, sq_x_q} + {1'b0, sq_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.scan_first) begin
      have_q <= 1'b0;
    end else if (v3_q) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && (!have_q || dist_sum < best_dist_q)) begin
      best_dist_q <= dist_sum;
      best_id_q   <= e3_id_q;
      best_x_q    <= e3_x_q;
      best_y_q    <= e3_y_q;
    end
  end

  // Result registers and done strobe
  logic            done_q;
  status_e         res_status_q;
  logic [IdW-1:0]  res_id_q;
  logic [PosW-1:0] res_x_q, res_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.fin_status;
      if (cmd_i.fin_match) begin
        res_id_q <= best_id_q;
        res_x_q  <= px_q - best_x_q;
        res_y_q  <= py_q - best_y_q;
      end else begin
        res_id_q <= '0;
        res_x_q  <= '0;
        res_y_q  <= '0;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    stat_o.count_zero = (count_q == '0);
    stat_o.count_full = (count_q == CW'(MaxLandmarks));
    stat_o.last_issue = (CW'(addr_q) == count_q - CW'(1));
    stat_o.pipe_idle  = !v1_q && !v2_q && !v3_q;
  end

  assign done_o       = done_q;
  assign status_o     = res_status_q;
  assign matched_id_o = res_id_q;
  assign residual_x_o = res_x_q;
  assign residual_y_o = res_y_q;

endmodule

// ----- src/nla_ctrl.sv -----
// Command decode and scan sequencing state machine.
module nla_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        command_i,
  input  nla_pkg::dp_stat_t stat_i,
  output nla_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o
);
  import nla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;

  // Decode the accepted beat and sequence the scan
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.fin_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          unique case (command_i)
            CMD_CLEAR: begin
              cmd_o.clear  = 1'b1;
              cmd_o.finish = 1'b1;
            end
            CMD_APPEND: begin
              cmd_o.append = 1'b1;
              cmd_o.finish = 1'b1;
              if (stat_i.count_full) begin
                cmd_o.fin_status = ST_FULL;
              end
            end
            CMD_QUERY: begin
              if (stat_i.count_zero) begin
                cmd_o.finish     = 1'b1;
                cmd_o.fin_status = ST_EMPTY;
              end else begin
                cmd_o.scan_first = 1'b1;
                state_d          = S_SCAN;
              end
            end
            default: begin
              cmd_o.finish = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (stat_i.last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat_i.pipe_idle) begin
          cmd_o.finish    = 1'b1;
          cmd_o.fin_match = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- src/nearest_landmark_association.sv -----
// Top level: nearest-landmark association block.
//
// Usage: drive command_i, landmark_id_i, pos_x_i and pos_y_i and raise start_i;
// the beat is taken at a rising edge where start_i is high and busy_o is low.
// Commands: clear the table, append a landmark, or query an observation.
// Every command gives exactly one result beat on status_o, matched_id_o,
// residual_x_o and residual_y_o, valid for the single cycle that done_o is high.
// Clear, append, unused codes and queries on an empty table: done_o is high in
// the cycle after acceptance and busy_o stays low, so one command per cycle.
// Query on n stored landmarks: busy_o is high while the scan reads the table
// through its single read port, one landmark per cycle, and while the
// four-stage distance pipeline (read, absolute difference, square, sum and
// compare) drains; done_o rises as busy_o falls, and the next beat can be
// taken at the edge that ends the done_o cycle.
// Reset empties the table and clears the controller and done strobe; table
// contents are never read before written. The receiver cannot stall: each
// result is taken in its one done_o cycle.
module nearest_landmark_association #(
  parameter int unsigned MAX_LANDMARKS = nla_pkg::MaxLandmarksDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      command_i,
  input  logic [nla_pkg::IdW-1:0]         landmark_id_i,
  input  logic signed [nla_pkg::PosW-1:0] pos_x_i,
  input  logic signed [nla_pkg::PosW-1:0] pos_y_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [nla_pkg::IdW-1:0]         matched_id_o,
  output logic signed [nla_pkg::PosW-1:0] residual_x_o,
  output logic signed [nla_pkg::PosW-1:0] residual_y_o
);
  import nla_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  nla_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .command_i(command_i),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd),
    .busy_o   (busy_o)
  );

  nla_datapath #(
    .MaxLandmarks(MAX_LANDMARKS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .landmark_id_i(landmark_id_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .matched_id_o (matched_id_o),
    .residual_x_o (residual_x_o),
    .residual_y_o (residual_y_o)
  );

endmodule

// ----- src/nla_checker.sv -----
// Port-level checker for the nearest-landmark association block, with its bind.
module nla_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            done_o,
  input logic [1:0]                      status_o,
  input logic [nla_pkg::IdW-1:0]         matched_id_o,
  input logic signed [nla_pkg::PosW-1:0] residual_x_o,
  input logic signed [nla_pkg::PosW-1:0] residual_y_o
);
  import nla_pkg::*;

  // An accepted beat either starts a scan or answers in the next cycle
  a_accept_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted beat neither scanned nor answered");

  // A finished scan always delivers its result
  a_scan_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("scan ended without a result beat");

  // No result beat while a scan is running
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result beat during scan");

  // Non-ok results carry zero payload
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |->
      (matched_id_o == '0) && (residual_x_o == '0) && (residual_y_o == '0))
    else $error("error result with nonzero payload");

endmodule

bind nearest_landmark_association nla_checker u_nla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .status_o    (status_o),
  .matched_id_o(matched_id_o),
  .residual_x_o(residual_x_o),
  .residual_y_o(residual_y_o)
);

// ----- tb/sv/nearest_landmark_association_test.sv -----
// Self-checking testbench for the nearest-landmark association block.
`timescale 1ns / 1ps

module nearest_landmark_association_test;
  import nla_pkg::*;

  localparam int unsigned TableDepth = MaxLandmarksDefault;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned RandomBeats = 1300;
  // Longest query: one read per entry plus the distance pipeline
  localparam int unsigned SettleCycles = TableDepth + 16;

  // Coordinate spreads for generated landmarks and observations
  localparam int unsigned SpreadWide = 0;
  localparam int unsigned SpreadCluster = 1;
  localparam int unsigned SpreadGrid = 2;

  typedef struct {
    logic [1:0]         command;
    logic [IdW-1:0]     id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    int unsigned        gap;    // idle cycles before this beat is offered
    bit                 drain;  // hold this beat until every result is back
  } beat_t;

  typedef struct {
    status_e            status;
    logic [IdW-1:0]     id;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
  } assoc_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [1:0]        command_i = CMD_CLEAR;
  logic [IdW-1:0]    landmark_id_i = '0;
  logic signed [PosW-1:0] pos_x_i = '0;
  logic signed [PosW-1:0] pos_y_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [1:0]        status_o;
  logic [IdW-1:0]    matched_id_o;
  logic signed [PosW-1:0] residual_x_o;
  logic signed [PosW-1:0] residual_y_o;

  nearest_landmark_association dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .landmark_id_i(landmark_id_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .matched_id_o (matched_id_o),
    .residual_x_o (residual_x_o),
    .residual_y_o (residual_y_o)
  );

  beat_t       cmd_backlog[$];
  assoc_t      assoc_due[$];
  beat_t       cur_beat;
  assoc_t      got_assoc;
  bit          took;
  bit          launch;
  int unsigned beats_taken = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned n_queued = 0;
  bit          burst = 1'b0;
  bit          hold_next = 1'b0;

  // Shadow landmark table
  logic [IdW-1:0]     lm_id[TableDepth];
  logic signed [31:0] lm_x[TableDepth];
  logic signed [31:0] lm_y[TableDepth];
  int unsigned        lm_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("FAIL nearest_landmark_association");
    $finish;
  end

  // Apply one command to the shadow table and return the association it yields
  function automatic assoc_t associate(input beat_t b);
    assoc_t      r;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] ax;
    logic [32:0] ay;
    logic [64:0] sq_dist;
    logic [64:0] best_dist;
    int unsigned best;
    r = '{status: ST_OK, id: '0, rx: '0, ry: '0};
    best = 0;
    best_dist = '0;
    case (b.command)
      CMD_CLEAR: begin
        lm_count = 0;
      end
      CMD_APPEND: begin
        if (lm_count < TableDepth) begin
          lm_id[lm_count] = b.id;
          lm_x[lm_count] = b.x;
          lm_y[lm_count] = b.y;
          lm_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_QUERY: begin
        if (lm_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Exact squared distance; strict compare keeps the earliest of a tie
          for (int unsigned j = 0; j < lm_count; j++) begin
            dx = {b.x[31], b.x} - {lm_x[j][31], lm_x[j]};
            dy = {b.y[31], b.y} - {lm_y[j][31], lm_y[j]};
            ax = dx[32] ? -dx : dx;
            ay = dy[32] ? -dy : dy;
            sq_dist = {32'b0, ax} * {32'b0, ax} + {32'b0, ay} * {32'b0, ay};
            if (j == 0 || sq_dist < best_dist) begin
              best_dist = sq_dist;
              best = j;
            end
          end
          r.id = lm_id[best];
          r.rx = b.x - lm_x[best];
          r.ry = b.y - lm_y[best];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Driver: offer queued beats, honoring gaps and drain holds
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      beats_taken <= 0;
      lm_count = 0;
    end else begin
      took = start_i && !busy_o;
      if (took) begin
        assoc_due.insert(assoc_due.size(), associate(cur_beat));
        beats_taken <= beats_taken + 1;
      end
      launch = 1'b0;
      if (!start_i || took) begin
        if (cmd_backlog.size() != 0) begin
          if (cmd_backlog[0].gap != 0) begin
            cmd_backlog[0].gap = cmd_backlog[0].gap - 1;
          end else if (!cmd_backlog[0].drain || (!took && beats_taken == results_seen)) begin
            launch = 1'b1;
          end
        end
        start_i <= launch;
      end
      if (launch) begin
        cur_beat = cmd_backlog.pop_front();
        command_i <= cur_beat.command;
        landmark_id_i <= cur_beat.id;
        pos_x_i <= cur_beat.x;
        pos_y_i <= cur_beat.y;
      end
    end
  end

  // Monitor: check each result beat against the oldest predicted association
  always @(posedge clk_i) begin
    if (done_o) begin
      results_seen <= results_seen + 1;
      if (assoc_due.size() == 0) begin
        $error("result beat with no command pending: status %0d id %h", status_o,
               matched_id_o);
        fail_count++;
      end else begin
        got_assoc = assoc_due.pop_front();
        if (status_o !== got_assoc.status) begin
          $error("status: expected %0d, got %0d", got_assoc.status, status_o);
          fail_count++;
        end
        if (matched_id_o !== got_assoc.id) begin
          $error("matched_id: expected %h, got %h", got_assoc.id, matched_id_o);
          fail_count++;
        end
        if (residual_x_o !== got_assoc.rx) begin
          $error("residual_x: expected %h, got %h", got_assoc.rx, residual_x_o);
          fail_count++;
        end
        if (residual_y_o !== got_assoc.ry) begin
          $error("residual_y: expected %h, got %h", got_assoc.ry, residual_y_o);
          fail_count++;
        end
      end
    end
  end

  // Queue one command beat with a random lead-in gap
  task automatic add_beat(input logic [1:0] cmd, input logic [IdW-1:0] id,
                          input logic [31:0] x, input logic [31:0] y);
    beat_t       b;
    int unsigned r;
    r = $urandom_range(0, 99);
    b.command = cmd;
    b.id = id;
    b.x = x;
    b.y = y;
    b.drain = hold_next;
    hold_next = 1'b0;
    if (burst || r < 60) begin
      b.gap = 0;
    end else if (r < 88) begin
      b.gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      b.gap = $urandom_range(4, 12);
    end else begin
      b.gap = $urandom_range(20, 80);
    end
    cmd_backlog.insert(cmd_backlog.size(), b);
    n_queued++;
  endtask

  function automatic logic [31:0] pick_coord(input int unsigned spread,
                                             input logic [31:0] centre);
    case (spread)
      SpreadCluster: return centre + 32'($urandom_range(0, 'h3FFFF)) - 32'h1FFFF;
      SpreadGrid:    return centre + ((32'($urandom_range(0, 4)) - 32'd2) << 16);
      default:       return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned roll;
    int unsigned spread;
    int unsigned n_lm;
    int unsigned n_obs;
    logic [31:0] cx;
    logic [31:0] cy;
    bit          fill;

    // Directed: empty query, unused code, extremes, ties, duplicates, wrap
    add_beat(CMD_QUERY, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    add_beat(CmdUnused, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_beat(CMD_APPEND, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_beat(CMD_APPEND, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_beat(CMD_QUERY, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_beat(CMD_QUERY, 16'h0000, 32'h8000_0000, 32'h8000_0000);
    add_beat(CMD_APPEND, 16'h1234, 32'h0000_0000, 32'h0000_0000);
    add_beat(CMD_APPEND, 16'h4321, 32'h0000_0000, 32'h0000_0000);
    add_beat(CMD_QUERY, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    add_beat(CMD_APPEND, 16'hA5A5, 32'h0001_0000, 32'h0000_0000);
    add_beat(CMD_APPEND, 16'h5A5A, 32'hFFFF_0000, 32'h0000_0000);
    add_beat(CMD_QUERY, 16'h0000, 32'h0000_8000, 32'h0000_0000);
    add_beat(CMD_QUERY, 16'h0000, 32'hFFFF_0001, 32'h0000_0000);
    add_beat(CmdUnused, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    add_beat(CMD_QUERY, 16'h0000, 32'h0001_0000, 32'h8000_0000);
    add_beat(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    add_beat(CMD_QUERY, 16'h0000, 32'h0000_0001, 32'h0000_0001);
    add_beat(CMD_APPEND, 16'h00FF, 32'h0000_0001, 32'hFFFF_FFFF);
    hold_next = 1'b1;
    add_beat(CMD_QUERY, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // Random: mostly clear/append/query sequences, some loose commands
    fill = 1'b1;
    while (n_queued < RandomBeats) begin
      roll = $urandom_range(0, 99);
      burst = ($urandom_range(0, 3) == 0);
      hold_next = ($urandom_range(0, 9) == 0);
      if (fill || roll < 75) begin
        spread = $urandom_range(SpreadWide, SpreadGrid);
        cx = $urandom;
        cy = $urandom;
        if (fill) begin
          n_lm = TableDepth + $urandom_range(1, 3);
        end else if ($urandom_range(0, 3) == 0) begin
          n_lm = $urandom_range(9, 40);
        end else begin
          n_lm = $urandom_range(1, 8);
        end
        n_obs = $urandom_range(1, 6);
        add_beat(CMD_CLEAR, 16'($urandom), $urandom, $urandom);
        for (int unsigned i = 0; i < n_lm; i++) begin
          add_beat(CMD_APPEND, 16'($urandom), pick_coord(spread, cx), pick_coord(spread, cy));
        end
        for (int unsigned i = 0; i < n_obs; i++) begin
          add_beat(CMD_QUERY, 16'($urandom), pick_coord(spread, cx), pick_coord(spread, cy));
        end
        fill = ($urandom_range(0, 99) < 4);
      end else begin
        // Loose commands on whatever the table holds
        n_obs = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n_obs; i++) begin
          add_beat(2'($urandom_range(0, 3)), 16'($urandom), $urandom, $urandom);
        end
      end
    end
    burst = 1'b0;

    // Wait for the backlog to drain and every result to come back
    do begin
      @(negedge clk_i);
    end while (cmd_backlog.size() != 0 || start_i || beats_taken != results_seen);
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0 && assoc_due.size() == 0) begin
      $display("PASS nearest_landmark_association");
    end else begin
      $display("FAIL nearest_landmark_association");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/nla_pkg.sv
src/nla_ram.sv
src/nla_datapath.sv
src/nla_ctrl.sv
src/nearest_landmark_association.sv
src/nla_checker.sv
tb/sv/nearest_landmark_association_test.sv
